>>> sv/sched_pkg.sv
// Shared types, constants and helper functions of the thread scheduler.
package sched_pkg;

  // Sizing of the scheduler.
  localparam int THREAD_SLOTS = 4;
  localparam int MUTEX_COUNT  = 4;

  // Thread indexes run from 0 to THREAD_SLOTS, plus one code meaning "none".
  localparam int IDX_W     = $clog2(THREAD_SLOTS + 2);
  localparam int LINK_AW   = $clog2(THREAD_SLOTS + 1);
  localparam int SLOT_W    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int MX_W      = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LINK_AW-1:0] link_addr_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [MX_W-1:0]    mx_idx_t;

  localparam idx_t INIT_IDX = idx_t'(THREAD_SLOTS);
  localparam idx_t NONE_IDX = idx_t'(THREAD_SLOTS + 1);

  // Request codes.
  typedef enum logic [2:0] {
    REQ_SPAWN  = 3'd0,
    REQ_YIELD  = 3'd1,
    REQ_LOCK   = 3'd2,
    REQ_UNLOCK = 3'd3,
    REQ_EXIT   = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SLOT     = 3'd1,
    ST_READY_EMPTY = 3'd2,
    ST_BAD_EXIT    = 3'd3,
    ST_HALTED      = 3'd4
  } status_t;

  // Which linked list a queue operation works on.
  typedef enum logic [1:0] {
    LST_FREE  = 2'd0,
    LST_READY = 2'd1,
    LST_WAIT  = 2'd2
  } list_t;

  // Input word.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [1:0]         mutex_id;
    logic [15:0]        spawn_entry;
    logic signed [15:0] spawn_arg;
  } sched_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         running_thread;
    logic [1:0]         spawned_slot;
    logic [15:0]        run_entry;
    logic signed [15:0] run_arg;
  } sched_out_t;

  // One mutex: wait queue pointers and lock bit.
  typedef struct packed {
    idx_t head;
    idx_t tail;
    logic locked;
  } mx_entry_t;

  localparam mx_entry_t MX_RESET = '{head: NONE_IDX, tail: NONE_IDX, locked: 1'b0};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    set_status;
    status_t status_code;
    logic    set_halt;
    logic    lock_set;
    logic    lock_clr;
    list_t   list;
    logic    push_a;
    logic    push_b;
    logic    push_slot;
    logic    pop_a;
    logic    pop_b;
    logic    pop_to_run;
    logic    fetch;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       halted;
    logic [2:0] req_type;
    logic       free_empty;
    logic       ready_empty;
    logic       wait_empty;
    logic       locked;
    logic       run_init;
    logic       sel_empty;
  } dp_sts_t;

  // Link value after reset: the free list chains the slots in order.
  function automatic idx_t link_reset(input idx_t i);
    idx_t r;
    if (i < idx_t'(THREAD_SLOTS - 1)) begin
      r = i + idx_t'(1);
    end else begin
      r = NONE_IDX;
    end
    return r;
  endfunction

  // Mutex number reduced into the range of existing mutexes.
  function automatic mx_idx_t mutex_sel(input logic [1:0] id);
    logic [7:0] v;
    v = {6'd0, id};
    for (int k = 0; k < 3; k++) begin
      if (v >= 8'(MUTEX_COUNT)) begin
        v = v - 8'(MUTEX_COUNT);
      end
    end
    return mx_idx_t'(v);
  endfunction

endpackage

>>> sv/sched_ctrl.sv
// Controller state machine of the thread scheduler: decodes a request into queue operations.
module sched_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sched_pkg::dp_sts_t sts,
  output logic               busy,
  output logic               out_valid,
  output sched_pkg::dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_PUSH_A = 8'b0000_0100,
    S_PUSH_B = 8'b0000_1000,
    S_POP_A  = 8'b0001_0000,
    S_POP_B  = 8'b0010_0000,
    S_FETCH  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  sched_pkg::list_t   push_list_r, push_list_nxt;
  sched_pkg::list_t   pop_list_r, pop_list_nxt;
  logic               spawn_r, spawn_nxt;

  // Next state, plan of queue operations and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    push_list_nxt   = push_list_r;
    pop_list_nxt    = pop_list_r;
    spawn_nxt       = spawn_r;
    cmd             = '0;
    cmd.list        = sched_pkg::LST_FREE;
    cmd.status_code = sched_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FETCH;
        spawn_nxt = 1'b0;
        if (sts.halted) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = sched_pkg::ST_HALTED;
        end else begin
          case (sts.req_type)
            sched_pkg::REQ_SPAWN: begin
              if (sts.free_empty) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = sched_pkg::ST_NO_SLOT;
                cmd.set_halt    = 1'b1;
              end else begin
                spawn_nxt     = 1'b1;
                pop_list_nxt  = sched_pkg::LST_FREE;
                push_list_nxt = sched_pkg::LST_READY;
                state_nxt     = S_POP_A;
              end
            end
            sched_pkg::REQ_YIELD: begin
              push_list_nxt = sched_pkg::LST_READY;
              pop_list_nxt  = sched_pkg::LST_READY;
              state_nxt     = S_PUSH_A;
            end
            sched_pkg::REQ_LOCK: begin
              if (!sts.locked) begin
                cmd.lock_set = 1'b1;
              end else if (sts.ready_empty) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = sched_pkg::ST_READY_EMPTY;
                cmd.set_halt    = 1'b1;
              end else begin
                push_list_nxt = sched_pkg::LST_WAIT;
                pop_list_nxt  = sched_pkg::LST_READY;
                state_nxt     = S_PUSH_A;
              end
            end
            sched_pkg::REQ_UNLOCK: begin
              if (!sts.wait_empty) begin
                push_list_nxt = sched_pkg::LST_READY;
                pop_list_nxt  = sched_pkg::LST_WAIT;
                state_nxt     = S_PUSH_A;
              end else begin
                cmd.lock_clr = 1'b1;
              end
            end
            sched_pkg::REQ_EXIT: begin
              if (sts.run_init) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = sched_pkg::ST_BAD_EXIT;
              end else if (sts.ready_empty) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = sched_pkg::ST_READY_EMPTY;
                cmd.set_halt    = 1'b1;
              end else begin
                push_list_nxt = sched_pkg::LST_FREE;
                pop_list_nxt  = sched_pkg::LST_READY;
                state_nxt     = S_PUSH_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH_A: begin
        cmd.push_a    = 1'b1;
        cmd.list      = push_list_r;
        cmd.push_slot = spawn_r;
        if (!sts.sel_empty) begin
          state_nxt = S_PUSH_B;
        end else if (spawn_r) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_POP_A;
        end
      end
      S_PUSH_B: begin
        cmd.push_b    = 1'b1;
        cmd.list      = push_list_r;
        cmd.push_slot = spawn_r;
        state_nxt     = spawn_r ? S_FETCH : S_POP_A;
      end
      S_POP_A: begin
        cmd.pop_a = 1'b1;
        cmd.list  = pop_list_r;
        state_nxt = S_POP_B;
      end
      S_POP_B: begin
        cmd.pop_b      = 1'b1;
        cmd.list       = pop_list_r;
        cmd.pop_to_run = !spawn_r;
        state_nxt      = spawn_r ? S_PUSH_A : S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and plan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      push_list_r <= sched_pkg::LST_FREE;
      pop_list_r  <= sched_pkg::LST_FREE;
      spawn_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      push_list_r <= push_list_nxt;
      pop_list_r  <= pop_list_nxt;
      spawn_r     <= spawn_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

>>> sv/sched_dp.sv
// Datapath of the thread scheduler: link table, queue pointers, mutex store and slot store.
module sched_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sched_pkg::sched_in_t  in_word,
  input  sched_pkg::dp_cmd_t    cmd,
  output sched_pkg::dp_sts_t    sts,
  output sched_pkg::sched_out_t out_word
);

  // Latched request.
  logic [2:0]                 req_r;
  sched_pkg::mx_idx_t         m_r;
  logic [15:0]                entry_in_r;
  logic signed [15:0]         arg_in_r;

  // Queue pointers; the wait queue of the addressed mutex is a working copy.
  sched_pkg::idx_t free_head_r, free_head_nxt, free_tail_r, free_tail_nxt;
  sched_pkg::idx_t ready_head_r, ready_head_nxt, ready_tail_r, ready_tail_nxt;
  sched_pkg::idx_t wh_r, wh_nxt, wt_r, wt_nxt;
  logic            lk_r, lk_nxt;

  sched_pkg::idx_t    running_r, popped_r, slot_r;
  logic               halted_r;
  sched_pkg::status_t status_r;
  logic [1:0]         spawned_r;
  logic [15:0]        run_entry_r;
  logic signed [15:0] run_arg_r;

  // Link table with valid bits; an entry not yet written reads its reset link.
  sched_pkg::idx_t             link_mem [0:sched_pkg::THREAD_SLOTS];
  logic [sched_pkg::THREAD_SLOTS:0] link_vld_r;
  sched_pkg::idx_t             link_rd_r;

  // Mutex store with valid bits.
  sched_pkg::mx_entry_t            mx_mem [0:sched_pkg::MUTEX_COUNT-1];
  logic [sched_pkg::MUTEX_COUNT-1:0] mx_vld_r;

  // Slot store of entry addresses and arguments.
  logic [15:0]        entry_mem [0:sched_pkg::THREAD_SLOTS-1];
  logic signed [15:0] arg_mem   [0:sched_pkg::THREAD_SLOTS-1];

  sched_pkg::mx_idx_t  m_in;
  sched_pkg::idx_t     head_sel, tail_sel, push_p, hd_new, tl_new;
  logic                hd_we, tl_we;
  logic                link_we;
  sched_pkg::idx_t     link_wa, link_wd;
  sched_pkg::link_addr_t link_wa_a, link_ra_a;
  sched_pkg::slot_t    pop_slot, run_slot;

  assign m_in      = sched_pkg::mutex_sel(in_word.mutex_id);
  assign push_p    = cmd.push_slot ? slot_r : running_r;
  assign link_ra_a = sched_pkg::link_addr_t'(head_sel);
  assign pop_slot  = sched_pkg::slot_t'(popped_r);
  assign run_slot  = sched_pkg::slot_t'(running_r);

  // Head and tail of the list that the current operation addresses.
  always_comb begin
    case (cmd.list)
      sched_pkg::LST_READY: begin
        head_sel = ready_head_r;
        tail_sel = ready_tail_r;
      end
      sched_pkg::LST_WAIT: begin
        head_sel = wh_r;
        tail_sel = wt_r;
      end
      default: begin
        head_sel = free_head_r;
        tail_sel = free_tail_r;
      end
    endcase
  end

  // New pointer values of a push or pop step.
  always_comb begin
    hd_we  = 1'b0;
    tl_we  = 1'b0;
    hd_new = head_sel;
    tl_new = tail_sel;
    if (cmd.push_a && (head_sel == sched_pkg::NONE_IDX)) begin
      hd_we  = 1'b1;
      tl_we  = 1'b1;
      hd_new = push_p;
      tl_new = push_p;
    end
    if (cmd.push_b) begin
      tl_we  = 1'b1;
      tl_new = push_p;
    end
    if (cmd.pop_b) begin
      hd_we  = 1'b1;
      hd_new = link_rd_r;
      if (link_rd_r == sched_pkg::NONE_IDX) begin
        tl_we  = 1'b1;
        tl_new = sched_pkg::NONE_IDX;
      end
    end
  end

  // Steer the pointer update to the addressed list.
  always_comb begin
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    wh_nxt         = wh_r;
    wt_nxt         = wt_r;
    case (cmd.list)
      sched_pkg::LST_READY: begin
        if (hd_we) ready_head_nxt = hd_new;
        if (tl_we) ready_tail_nxt = tl_new;
      end
      sched_pkg::LST_WAIT: begin
        if (hd_we) wh_nxt = hd_new;
        if (tl_we) wt_nxt = tl_new;
      end
      default: begin
        if (hd_we) free_head_nxt = hd_new;
        if (tl_we) free_tail_nxt = tl_new;
      end
    endcase
    lk_nxt = lk_r;
    if (cmd.lock_set) lk_nxt = 1'b1;
    if (cmd.lock_clr) lk_nxt = 1'b0;
  end

  // Link table write: the pushed entry ends its list, then the old tail points at it.
  assign link_we   = cmd.push_a || cmd.push_b;
  assign link_wa   = cmd.push_a ? push_p : tail_sel;
  assign link_wd   = cmd.push_a ? sched_pkg::NONE_IDX : push_p;
  assign link_wa_a = sched_pkg::link_addr_t'(link_wa);

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= sched_pkg::idx_t'(0);
      free_tail_r  <= sched_pkg::idx_t'(sched_pkg::THREAD_SLOTS - 1);
      ready_head_r <= sched_pkg::NONE_IDX;
      ready_tail_r <= sched_pkg::NONE_IDX;
      running_r    <= sched_pkg::INIT_IDX;
      halted_r     <= 1'b0;
      link_vld_r   <= '0;
      mx_vld_r     <= '0;
    end else begin
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      if (cmd.pop_b && cmd.pop_to_run) begin
        running_r <= popped_r;
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      if (link_we) begin
        link_vld_r[link_wa_a] <= 1'b1;
      end
      if (cmd.fetch) begin
        mx_vld_r[m_r] <= 1'b1;
      end
    end
  end

  // Request latch, mutex read and working copy.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r      <= in_word.req_type;
      m_r        <= m_in;
      entry_in_r <= in_word.spawn_entry;
      arg_in_r   <= in_word.spawn_arg;
      status_r   <= sched_pkg::ST_OK;
      spawned_r  <= 2'd0;
      if (mx_vld_r[m_in]) begin
        {wh_r, wt_r, lk_r} <= mx_mem[m_in];
      end else begin
        {wh_r, wt_r, lk_r} <= sched_pkg::MX_RESET;
      end
    end else begin
      wh_r <= wh_nxt;
      wt_r <= wt_nxt;
      lk_r <= lk_nxt;
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.pop_b && !cmd.pop_to_run) begin
        spawned_r <= 2'(popped_r);
      end
    end
  end

  // Link table port: one write, one registered read of the list head.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa_a] <= link_wd;
    end
    if (cmd.pop_a) begin
      popped_r <= head_sel;
      if (link_vld_r[link_ra_a]) begin
        link_rd_r <= link_mem[link_ra_a];
      end else begin
        link_rd_r <= sched_pkg::link_reset(head_sel);
      end
    end
  end

  // Slot store: written when a spawn takes its slot, read for the running thread.
  always_ff @(posedge clk) begin
    if (cmd.pop_b && !cmd.pop_to_run) begin
      slot_r              <= popped_r;
      entry_mem[pop_slot] <= entry_in_r;
      arg_mem[pop_slot]   <= arg_in_r;
    end
    if (cmd.fetch) begin
      if (running_r != sched_pkg::INIT_IDX) begin
        run_entry_r <= entry_mem[run_slot];
        run_arg_r   <= arg_mem[run_slot];
      end else begin
        run_entry_r <= 16'd0;
        run_arg_r   <= 16'sd0;
      end
    end
  end

  // Mutex store write-back at the end of each request.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mx_mem[m_r] <= {wh_r, wt_r, lk_r};
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.halted      = halted_r;
    sts.req_type    = req_r;
    sts.free_empty  = (free_head_r == sched_pkg::NONE_IDX);
    sts.ready_empty = (ready_head_r == sched_pkg::NONE_IDX);
    sts.wait_empty  = (wh_r == sched_pkg::NONE_IDX);
    sts.locked      = lk_r;
    sts.run_init    = (running_r == sched_pkg::INIT_IDX);
    sts.sel_empty   = (head_sel == sched_pkg::NONE_IDX);
  end

  // Result word.
  always_comb begin
    out_word.status         = status_r;
    out_word.running_thread = 3'(running_r);
    out_word.spawned_slot   = spawned_r;
    out_word.run_entry      = run_entry_r;
    out_word.run_arg        = run_arg_r;
  end

  // A list is empty at its head exactly when it is empty at its tail.
  a_free_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == sched_pkg::NONE_IDX) == (free_tail_r == sched_pkg::NONE_IDX))
    else $error("free list head and tail disagree on emptiness");

  a_ready_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_head_r == sched_pkg::NONE_IDX) == (ready_tail_r == sched_pkg::NONE_IDX))
    else $error("ready queue head and tail disagree on emptiness");

  // Some thread always runs.
  a_running_valid: assert property (@(posedge clk) disable iff (!rst_n)
    running_r != sched_pkg::NONE_IDX)
    else $error("running thread is the empty code");

  // A pop is only started on a non-empty list.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_a |-> (head_sel != sched_pkg::NONE_IDX))
    else $error("pop issued on an empty list");

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

endmodule

>>> sv/thread_scheduler_with_mutexes.sv
// Top level of the hardware thread scheduler with mutexes.
//
// Usage: present a request word on in_word and raise start; the word is taken at
// a rising edge where start is high and busy is low. busy stays high until the
// result has been shown. Each request gives exactly one result word on out_word,
// marked by out_valid for a single cycle; the receiver cannot hold it off.
// A request that moves no queue entry (lock of a free mutex, unlock with no waiter,
// errors, halted) passes from the decide state through fetch to the result state;
// yield, blocking lock, handing unlock, exit and spawn add queue steps in between.
// They work on the link table: a push takes one write, plus a second when the list
// already holds an entry, and a pop takes a registered read and an update. A new
// request is taken in the cycle after out_valid.
// Reset (rst_n low, synchronous) empties the ready and wait queues, frees all
// slots, unlocks all mutexes, clears the halt flag and makes the initial thread
// run. After a panic the block answers every request with the halted status.
module thread_scheduler_with_mutexes (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  sched_pkg::sched_in_t  in_word,
  output logic                  out_valid,
  output sched_pkg::sched_out_t out_word
);

  sched_pkg::dp_cmd_t cmd;
  sched_pkg::dp_sts_t sts;

  // Request sequencer.
  sched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Queues, mutexes and thread slots.
  sched_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

>>> test/sched_checker.sv
// Scoreboard for the thread scheduler: mirrors its lists, predicts each result word and compares.
module sched_checker (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic                                         busy,
  input  sched_pkg::sched_in_t                         in_word,
  input  logic                                         out_valid,
  input  sched_pkg::sched_out_t                        out_word,
  output int                                           errors,
  output int                                           pending,
  output logic [2:0]                                   n_free,
  output logic [2:0]                                   n_ready,
  output logic [sched_pkg::MUTEX_COUNT-1:0]            mx_held,
  output logic                                         run_init
);
  timeunit 1ns;
  timeprecision 1ps;

  // Every list lives in one table: the free list, the ready queue, then one wait queue per mutex.
  localparam int FREE_LIST  = 0;
  localparam int READY_LIST = 1;
  localparam int WAIT_LIST0 = 2;
  localparam int NUM_LISTS  = sched_pkg::MUTEX_COUNT + 2;

  sched_pkg::idx_t                   link_tab [0:sched_pkg::THREAD_SLOTS];
  sched_pkg::idx_t                   lst_head [0:NUM_LISTS-1];
  sched_pkg::idx_t                   lst_tail [0:NUM_LISTS-1];
  int                                lst_len  [0:NUM_LISTS-1];
  logic [sched_pkg::MUTEX_COUNT-1:0] held;
  sched_pkg::idx_t                   cur;
  logic [15:0]                       entry_of [0:sched_pkg::THREAD_SLOTS-1];
  logic [15:0]                       arg_of   [0:sched_pkg::THREAD_SLOTS-1];
  logic                              halted;
  sched_pkg::sched_out_t             expected_q [$];
  sched_pkg::sched_out_t             want_word;

  // Append a thread at the tail of a list.
  function automatic void list_push(int l, sched_pkg::idx_t p);
    link_tab[p] = sched_pkg::NONE_IDX;
    if (lst_head[l] == sched_pkg::NONE_IDX) begin
      lst_head[l] = p;
    end else begin
      link_tab[lst_tail[l]] = p;
    end
    lst_tail[l] = p;
    lst_len[l]++;
  endfunction

  // Take the thread at the head of a list; only called on a list that holds one.
  function automatic sched_pkg::idx_t list_pop(int l);
    sched_pkg::idx_t p;
    p = lst_head[l];
    lst_head[l] = link_tab[p];
    if (lst_head[l] == sched_pkg::NONE_IDX) begin
      lst_tail[l] = sched_pkg::NONE_IDX;
    end
    lst_len[l]--;
    return p;
  endfunction

  // State after reset: all slots free in order, the initial thread running.
  function automatic void clear_state();
    for (int i = 0; i <= sched_pkg::THREAD_SLOTS; i++) begin
      link_tab[i] = (i < sched_pkg::THREAD_SLOTS - 1) ? sched_pkg::idx_t'(i + 1)
                                                       : sched_pkg::NONE_IDX;
    end
    for (int l = 0; l < NUM_LISTS; l++) begin
      lst_head[l] = sched_pkg::NONE_IDX;
      lst_tail[l] = sched_pkg::NONE_IDX;
      lst_len[l]  = 0;
    end
    lst_head[FREE_LIST] = sched_pkg::idx_t'(0);
    lst_tail[FREE_LIST] = sched_pkg::idx_t'(sched_pkg::THREAD_SLOTS - 1);
    lst_len[FREE_LIST]  = sched_pkg::THREAD_SLOTS;
    for (int s = 0; s < sched_pkg::THREAD_SLOTS; s++) begin
      entry_of[s] = '0;
      arg_of[s]   = '0;
    end
    held   = '0;
    cur    = sched_pkg::INIT_IDX;
    halted = 1'b0;
  endfunction

  // Carry out one request on the mirrored state and return the word it should produce.
  function automatic sched_pkg::sched_out_t schedule(sched_pkg::sched_in_t w);
    sched_pkg::sched_out_t r;
    int                    m;
    sched_pkg::idx_t       s;
    r = '0;
    m = int'(w.mutex_id) % sched_pkg::MUTEX_COUNT;
    r.status = sched_pkg::ST_OK;
    if (halted) begin
      r.status = sched_pkg::ST_HALTED;
    end else begin
      case (w.req_type)
        sched_pkg::REQ_SPAWN: begin
          if (lst_len[FREE_LIST] == 0) begin
            r.status = sched_pkg::ST_NO_SLOT;
            halted   = 1'b1;
          end else begin
            s = list_pop(FREE_LIST);
            entry_of[s] = w.spawn_entry;
            arg_of[s]   = w.spawn_arg;
            list_push(READY_LIST, s);
            r.spawned_slot = 2'(s);
          end
        end
        sched_pkg::REQ_YIELD: begin
          list_push(READY_LIST, cur);
          cur = list_pop(READY_LIST);
        end
        sched_pkg::REQ_LOCK: begin
          if (!held[m]) begin
            held[m] = 1'b1;
          end else if (lst_len[READY_LIST] == 0) begin
            r.status = sched_pkg::ST_READY_EMPTY;
            halted   = 1'b1;
          end else begin
            list_push(WAIT_LIST0 + m, cur);
            cur = list_pop(READY_LIST);
          end
        end
        sched_pkg::REQ_UNLOCK: begin
          // A waiter inherits the mutex; otherwise the lock is simply dropped.
          if (lst_len[WAIT_LIST0 + m] != 0) begin
            list_push(READY_LIST, cur);
            cur = list_pop(WAIT_LIST0 + m);
          end else begin
            held[m] = 1'b0;
          end
        end
        sched_pkg::REQ_EXIT: begin
          if (cur == sched_pkg::INIT_IDX) begin
            r.status = sched_pkg::ST_BAD_EXIT;
          end else if (lst_len[READY_LIST] == 0) begin
            r.status = sched_pkg::ST_READY_EMPTY;
            halted   = 1'b1;
          end else begin
            list_push(FREE_LIST, cur);
            cur = list_pop(READY_LIST);
          end
        end
        default: begin
        end
      endcase
    end
    r.running_thread = 3'(cur);
    if (cur < sched_pkg::INIT_IDX) begin
      r.run_entry = entry_of[cur];
      r.run_arg   = arg_of[cur];
    end
    return r;
  endfunction

  // Report one field that differs from its expectation.
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare result words first, then predict any word taken at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_q.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: expected none, actual %p",
                   $time, out_word);
          errors++;
        end else begin
          want_word = expected_q.pop_front();
          check_field("status", 16'(want_word.status), 16'(out_word.status));
          check_field("running_thread", 16'(want_word.running_thread),
                      16'(out_word.running_thread));
          check_field("spawned_slot", 16'(want_word.spawned_slot), 16'(out_word.spawned_slot));
          check_field("run_entry", want_word.run_entry, out_word.run_entry);
          check_field("run_arg", want_word.run_arg, out_word.run_arg);
        end
      end
      if (start && !busy) begin
        expected_q.push_back(schedule(in_word));
      end
    end
    pending  = expected_q.size();
    n_free   = 3'(lst_len[FREE_LIST]);
    n_ready  = 3'(lst_len[READY_LIST]);
    mx_held  = held;
    run_init = (cur == sched_pkg::INIT_IDX);
  end

endmodule

>>> test/testbench.sv
// Top of the scheduler testbench: clock, reset, request stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes the block ignores.
  localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REQ_LAST_CODE    = 3'd7;

  // The ways the final panic can be provoked.
  localparam int PANIC_NO_SLOT = 0;
  localparam int PANIC_LOCK    = 1;
  localparam int PANIC_EXIT    = 2;

  localparam int ITEM_TARGET = 400;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  sched_pkg::sched_in_t              in_word;
  logic                              out_valid;
  sched_pkg::sched_out_t             out_word;
  int                                errors;
  int                                pending;
  logic [2:0]                        n_free;
  logic [2:0]                        n_ready;
  logic [sched_pkg::MUTEX_COUNT-1:0] mx_held;
  logic                              run_init;
  int                                burst_left = 1;

  always #1 clk = ~clk;

  thread_scheduler_with_mutexes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  sched_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending),
    .n_free    (n_free),
    .n_ready   (n_ready),
    .mx_held   (mx_held),
    .run_init  (run_init)
  );

  function automatic sched_pkg::sched_in_t req_word(logic [2:0] kind, int m, logic [15:0] e,
                                                    logic [15:0] a);
    sched_pkg::sched_in_t w;
    w.req_type    = kind;
    w.mutex_id    = 2'(m);
    w.spawn_entry = e;
    w.spawn_arg   = a;
    return w;
  endfunction

  function automatic sched_pkg::sched_in_t any_word(logic [2:0] kind, int m);
    return req_word(kind, m, 16'($urandom), 16'($urandom));
  endfunction

  // A mostly legal request: anything that would halt the block is swapped for a harmless one.
  function automatic sched_pkg::sched_in_t random_word();
    int         roll;
    int         m;
    logic [2:0] kind;
    roll = $urandom_range(0, 99);
    m    = $urandom_range(0, sched_pkg::MUTEX_COUNT - 1);
    if (roll < 20) begin
      kind = sched_pkg::REQ_SPAWN;
    end else if (roll < 45) begin
      kind = sched_pkg::REQ_YIELD;
    end else if (roll < 70) begin
      kind = sched_pkg::REQ_LOCK;
    end else if (roll < 88) begin
      kind = sched_pkg::REQ_UNLOCK;
      // Favour mutexes that are held, so that waiters get handed the lock.
      if (mx_held != '0 && $urandom_range(0, 1) == 1) begin
        do begin
          m = $urandom_range(0, sched_pkg::MUTEX_COUNT - 1);
        end while (!mx_held[m]);
      end
    end else if (roll < 96) begin
      kind = sched_pkg::REQ_EXIT;
    end else begin
      kind = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
    end
    if (kind == sched_pkg::REQ_SPAWN && n_free == 0) begin
      kind = sched_pkg::REQ_YIELD;
    end else if (kind == sched_pkg::REQ_LOCK && mx_held[m] && n_ready == 0) begin
      kind = sched_pkg::REQ_UNLOCK;
    end else if (kind == sched_pkg::REQ_EXIT && n_ready == 0 && !run_init) begin
      kind = sched_pkg::REQ_YIELD;
    end
    return any_word(kind, m);
  endfunction

  // Offer one word until it is taken; at the end of a burst, idle for a while.
  task automatic send(sched_pkg::sched_in_t w);
    int gap;
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(1, 12);
      start   <= 1'b0;
      in_word <= any_word(3'($urandom), $urandom_range(0, 3));
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding result word has come back.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int done;
    int m;
    int panic_kind;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: empty-queue yield, exit of the initial thread, plain lock and unlock.
    send(any_word(sched_pkg::REQ_YIELD, 0));
    send(any_word(sched_pkg::REQ_EXIT, 0));
    send(any_word(sched_pkg::REQ_LOCK, 0));
    send(any_word(sched_pkg::REQ_UNLOCK, 0));
    send(any_word(sched_pkg::REQ_UNLOCK, 1));
    // Fill every slot, with extreme entries and arguments.
    send(req_word(sched_pkg::REQ_SPAWN, 0, 16'h0000, 16'h8000));
    send(req_word(sched_pkg::REQ_SPAWN, 1, 16'hffff, 16'h7fff));
    send(req_word(sched_pkg::REQ_SPAWN, 2, 16'h5555, 16'h2aaa));
    send(req_word(sched_pkg::REQ_SPAWN, 3, 16'haaaa, 16'hd555));
    // Contention on one mutex: two threads park, the first two unlocks hand it on, the third frees it.
    send(any_word(sched_pkg::REQ_YIELD, 0));
    send(any_word(sched_pkg::REQ_LOCK, 3));
    send(any_word(sched_pkg::REQ_YIELD, 0));
    send(any_word(sched_pkg::REQ_LOCK, 3));
    send(any_word(sched_pkg::REQ_LOCK, 3));
    send(any_word(sched_pkg::REQ_UNLOCK, 3));
    send(any_word(sched_pkg::REQ_UNLOCK, 3));
    send(any_word(sched_pkg::REQ_UNLOCK, 3));
    send(any_word(sched_pkg::REQ_EXIT, 2));
    // Unused request codes are ignored.
    send(any_word(REQ_FIRST_UNUSED, 1));
    send(any_word(3'(REQ_FIRST_UNUSED + 3'd1), 2));
    send(any_word(REQ_LAST_CODE, 3));
    send(any_word(sched_pkg::REQ_EXIT, 0));
    send(any_word(sched_pkg::REQ_SPAWN, 1));
    send(any_word(sched_pkg::REQ_LOCK, 2));
    send(any_word(sched_pkg::REQ_UNLOCK, 2));

    // Random traffic, with one full pause half way through.
    done = 0;
    while (done < ITEM_TARGET / 2) begin
      send(random_word());
      done++;
    end
    wait_quiet();
    while (done < ITEM_TARGET) begin
      send(random_word());
      done++;
    end

    // Release every mutex and drain the ready queue, then provoke one panic.
    for (m = 0; m < sched_pkg::MUTEX_COUNT; m++) begin
      while (mx_held[m]) send(any_word(sched_pkg::REQ_UNLOCK, m));
    end
    while (n_ready != 0) begin
      send(any_word(run_init ? sched_pkg::REQ_YIELD : sched_pkg::REQ_EXIT, 0));
    end
    panic_kind = $urandom_range(PANIC_NO_SLOT, PANIC_EXIT);
    m = $urandom_range(0, sched_pkg::MUTEX_COUNT - 1);
    case (panic_kind)
      PANIC_NO_SLOT: begin
        while (n_free != 0) send(any_word(sched_pkg::REQ_SPAWN, m));
        send(any_word(sched_pkg::REQ_SPAWN, m));
      end
      PANIC_LOCK: begin
        send(any_word(sched_pkg::REQ_LOCK, m));
        send(any_word(sched_pkg::REQ_LOCK, m));
      end
      default: begin
        // The initial thread parks itself so that a slot runs with nothing ready behind it.
        if (run_init) begin
          send(any_word(sched_pkg::REQ_SPAWN, m));
          send(any_word(sched_pkg::REQ_LOCK, m));
          send(any_word(sched_pkg::REQ_LOCK, m));
        end
        send(any_word(sched_pkg::REQ_EXIT, m));
      end
    endcase
    // Once halted, every request answers with the halted status.
    repeat (6) send(any_word(3'($urandom_range(0, 7)), $urandom_range(0, 3)));

    wait_quiet();
    repeat (12) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule
